>>> hdl/mau_pkg.sv
// ============================================================================
// mau_pkg
// Shared widths, command codes, microcode format and control store for the
// modular arithmetic unit.
// ============================================================================
package mau_pkg;

  localparam int MOD_W  = 31;                      // modulus and residue width
  localparam int OPND_W = 64;                      // operand width
  localparam int CMD_W  = 3;
  localparam int PROD_W = 2 * MOD_W;
  localparam int CNT_W  = $clog2(OPND_W + 1);      // reducer bit counter
  localparam int PC_W   = 5;

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POW = 3'd4;

  typedef enum logic [4:0] {
    UOP_NOP,
    UOP_LOAD,          // wait for and latch an input item
    UOP_RED_A,         // ra <= operand_a mod m
    UOP_RED_B,         // rb <= operand_b mod m
    UOP_ADD,
    UOP_SUB,
    UOP_ZERO,
    UOP_ONE,
    UOP_PMUL_AB,       // prod <= ra * rb
    UOP_PMUL_ACC_BASE, // prod <= acc * base
    UOP_PMUL_BASE_SQ,  // prod <= base * base
    UOP_PMUL_RA_ACC,   // prod <= ra * acc
    UOP_RED_P_RES,     // res  <= prod mod m
    UOP_RED_P_ACC,     // acc  <= prod mod m
    UOP_RED_P_BASE,    // base <= prod mod m
    UOP_INIT_DIV,      // acc <= 1, base <= rb, exp <= m - 2
    UOP_INIT_POW,      // acc <= 1, base <= ra, exp <= b
    UOP_EXP_SHIFT,
    UOP_MOV_ACC,       // res <= acc
    UOP_OUT            // hand res to the output register
  } uop_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_M_LT2,
    COND_IS_ADD,
    COND_IS_SUB,
    COND_IS_MUL,
    COND_IS_DIV,
    COND_IS_POW,
    COND_RB_ZERO,
    COND_B_NONPOS,
    COND_EXP_ZERO,
    COND_EXP_EVEN
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // reducer request / status
  typedef struct packed {
    logic start;
    logic negate;
  } red_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } red_stat_t;

  typedef enum logic [1:0] {
    RED_IDLE,
    RED_RUN,
    RED_FIX,
    RED_DONE
  } red_state_t;

  // program labels
  localparam logic [PC_W-1:0] S_LOAD    = 5'd0;
  localparam logic [PC_W-1:0] S_ZERO    = 5'd9;
  localparam logic [PC_W-1:0] S_ADD     = 5'd10;
  localparam logic [PC_W-1:0] S_SUB     = 5'd11;
  localparam logic [PC_W-1:0] S_MUL     = 5'd12;
  localparam logic [PC_W-1:0] S_DIV     = 5'd14;
  localparam logic [PC_W-1:0] S_POW     = 5'd16;
  localparam logic [PC_W-1:0] S_LOOP    = 5'd18;
  localparam logic [PC_W-1:0] S_SQ      = 5'd22;
  localparam logic [PC_W-1:0] S_FIN     = 5'd25;
  localparam logic [PC_W-1:0] S_DIV_FIN = 5'd27;
  localparam logic [PC_W-1:0] S_ONE     = 5'd29;
  localparam logic [PC_W-1:0] S_OUT     = 5'd30;

  // control store
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{UOP_NOP, COND_ALWAYS, S_LOAD};
    case (pc)
      5'd0:  w = '{UOP_LOAD,          COND_NEVER,    S_LOAD};
      5'd1:  w = '{UOP_NOP,           COND_M_LT2,    S_ZERO};
      5'd2:  w = '{UOP_RED_A,         COND_NEVER,    S_LOAD};
      5'd3:  w = '{UOP_RED_B,         COND_NEVER,    S_LOAD};
      5'd4:  w = '{UOP_NOP,           COND_IS_ADD,   S_ADD};
      5'd5:  w = '{UOP_NOP,           COND_IS_SUB,   S_SUB};
      5'd6:  w = '{UOP_NOP,           COND_IS_MUL,   S_MUL};
      5'd7:  w = '{UOP_NOP,           COND_IS_DIV,   S_DIV};
      5'd8:  w = '{UOP_NOP,           COND_IS_POW,   S_POW};
      5'd9:  w = '{UOP_ZERO,          COND_ALWAYS,   S_OUT};
      5'd10: w = '{UOP_ADD,           COND_ALWAYS,   S_OUT};
      5'd11: w = '{UOP_SUB,           COND_ALWAYS,   S_OUT};
      5'd12: w = '{UOP_PMUL_AB,       COND_NEVER,    S_LOAD};
      5'd13: w = '{UOP_RED_P_RES,     COND_ALWAYS,   S_OUT};
      5'd14: w = '{UOP_NOP,           COND_RB_ZERO,  S_ZERO};
      5'd15: w = '{UOP_INIT_DIV,      COND_ALWAYS,   S_LOOP};
      5'd16: w = '{UOP_NOP,           COND_B_NONPOS, S_ONE};
      5'd17: w = '{UOP_INIT_POW,      COND_NEVER,    S_LOAD};
      5'd18: w = '{UOP_NOP,           COND_EXP_ZERO, S_FIN};
      5'd19: w = '{UOP_NOP,           COND_EXP_EVEN, S_SQ};
      5'd20: w = '{UOP_PMUL_ACC_BASE, COND_NEVER,    S_LOAD};
      5'd21: w = '{UOP_RED_P_ACC,     COND_NEVER,    S_LOAD};
      5'd22: w = '{UOP_PMUL_BASE_SQ,  COND_NEVER,    S_LOAD};
      5'd23: w = '{UOP_RED_P_BASE,    COND_NEVER,    S_LOAD};
      5'd24: w = '{UOP_EXP_SHIFT,     COND_ALWAYS,   S_LOOP};
      5'd25: w = '{UOP_NOP,           COND_IS_DIV,   S_DIV_FIN};
      5'd26: w = '{UOP_MOV_ACC,       COND_ALWAYS,   S_OUT};
      5'd27: w = '{UOP_PMUL_RA_ACC,   COND_NEVER,    S_LOAD};
      5'd28: w = '{UOP_RED_P_RES,     COND_ALWAYS,   S_OUT};
      5'd29: w = '{UOP_ONE,           COND_NEVER,    S_LOAD};
      5'd30: w = '{UOP_OUT,           COND_ALWAYS,   S_LOAD};
      default: w = '{UOP_NOP,         COND_ALWAYS,   S_LOAD};
    endcase
    return w;
  endfunction

endpackage

>>> hdl/mau_reduce.sv
// ============================================================================
// mau_reduce
// Bit-serial reducer: residue of a 64-bit value (optionally a negative one)
// modulo m, one dividend bit per cycle.
// ============================================================================
module mau_reduce (
  input  logic                         clk,
  input  logic                         rst,
  input  mau_pkg::red_req_t            req,
  input  logic [mau_pkg::OPND_W-1:0]   value,
  input  logic [mau_pkg::MOD_W-1:0]    m,
  output mau_pkg::red_stat_t           stat,
  output logic [mau_pkg::MOD_W-1:0]    residue
);

  mau_pkg::red_state_t state, state_next;

  logic [mau_pkg::OPND_W-1:0] dividend;
  logic [mau_pkg::MOD_W-1:0]  rem;
  logic [mau_pkg::CNT_W-1:0]  cnt;
  logic                       neg;
  logic [mau_pkg::MOD_W:0]    trial;

  // partial remainder with next dividend bit; always below 2m
  assign trial = {rem, dividend[mau_pkg::OPND_W-1]};

  always_comb begin
    state_next = state;
    case (state)
      mau_pkg::RED_IDLE: if (req.start) state_next = mau_pkg::RED_RUN;
      mau_pkg::RED_RUN:  if (cnt == mau_pkg::CNT_W'(1)) state_next = mau_pkg::RED_FIX;
      mau_pkg::RED_FIX:  state_next = mau_pkg::RED_DONE;
      mau_pkg::RED_DONE: state_next = mau_pkg::RED_IDLE;
      default:           state_next = mau_pkg::RED_IDLE;
    endcase
  end

  always_comb begin
    stat.idle = (state == mau_pkg::RED_IDLE);
    stat.done = (state == mau_pkg::RED_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mau_pkg::RED_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mau_pkg::RED_IDLE: begin
        if (req.start) begin
          dividend <= req.negate ? (mau_pkg::OPND_W'(0) - value) : value;
          rem      <= '0;
          cnt      <= mau_pkg::CNT_W'(mau_pkg::OPND_W);
          neg      <= req.negate;
        end
      end
      mau_pkg::RED_RUN: begin
        if (trial >= {1'b0, m}) begin
          rem <= mau_pkg::MOD_W'(trial - {1'b0, m});
        end else begin
          rem <= mau_pkg::MOD_W'(trial);
        end
        dividend <= {dividend[mau_pkg::OPND_W-2:0], 1'b0};
        cnt      <= cnt - mau_pkg::CNT_W'(1);
      end
      mau_pkg::RED_FIX: begin
        // residue of a negative value: m - r, or zero
        if (neg && rem != '0) rem <= m - rem;
      end
      default: begin
      end
    endcase
  end

  assign residue = rem;

endmodule

>>> hdl/modular_arithmetic_unit.sv
// ============================================================================
// modular_arithmetic_unit
// Modular add, subtract, multiply, Fermat divide and power under a
// programmable modulus, run by a small microcoded sequencer.
// ============================================================================
// Every reduction runs in the one shared bit-serial reducer; divide and power
//   loop once per exponent bit, over up to 31 bits of m-2 for divide and up to
//   63 bits of exponent for power.
// Throughput: one item at a time; the next item is taken once the program is
//   back at its load step, even while a result waits in the output register.
// Reset: sequencer to the load step, output empty, modulus = 1000000007.
module modular_arithmetic_unit (
  input  logic                                clk,
  input  logic                                rst,
  // configuration: modulus
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mau_pkg::MOD_W-1:0]           modulus,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mau_pkg::CMD_W-1:0]           command,
  input  logic signed [mau_pkg::OPND_W-1:0]   operand_a,
  input  logic signed [mau_pkg::OPND_W-1:0]   operand_b,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mau_pkg::MOD_W-1:0]           result
);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [mau_pkg::MOD_W-1:0]  mod_value;   // current modulus
  logic [mau_pkg::PC_W-1:0]   pc, pc_next;
  logic [mau_pkg::CMD_W-1:0]  cmd;
  logic [mau_pkg::OPND_W-1:0] a_raw, b_raw;
  logic [mau_pkg::MOD_W-1:0]  ra, rb;      // reduced operands
  logic [mau_pkg::MOD_W-1:0]  acc, base;   // square-and-multiply state
  logic [mau_pkg::OPND_W-1:0] exp;
  logic [mau_pkg::PROD_W-1:0] prod;        // registered multiplier output
  logic [mau_pkg::MOD_W-1:0]  res;

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  mau_pkg::ctrl_word_t cw;
  logic                taken;
  logic                stall;
  logic                advance;
  logic                is_red;

  mau_pkg::red_req_t          red_req;
  mau_pkg::red_stat_t         red_stat;
  logic [mau_pkg::OPND_W-1:0] red_value;
  logic [mau_pkg::MOD_W-1:0]  red_residue;

  logic [mau_pkg::MOD_W-1:0]  mul_x, mul_y;
  logic [mau_pkg::MOD_W:0]    sum, diff;

  assign cw = mau_pkg::ucode(pc);

  // jump condition
  always_comb begin
    case (cw.cond)
      mau_pkg::COND_NEVER:    taken = 1'b0;
      mau_pkg::COND_ALWAYS:   taken = 1'b1;
      mau_pkg::COND_M_LT2:    taken = (mod_value < mau_pkg::MOD_W'(2));
      mau_pkg::COND_IS_ADD:   taken = (cmd == mau_pkg::CMD_ADD);
      mau_pkg::COND_IS_SUB:   taken = (cmd == mau_pkg::CMD_SUB);
      mau_pkg::COND_IS_MUL:   taken = (cmd == mau_pkg::CMD_MUL);
      mau_pkg::COND_IS_DIV:   taken = (cmd == mau_pkg::CMD_DIV);
      mau_pkg::COND_IS_POW:   taken = (cmd == mau_pkg::CMD_POW);
      mau_pkg::COND_RB_ZERO:  taken = (rb == '0);
      // exponent zero or negative
      mau_pkg::COND_B_NONPOS: taken = b_raw[mau_pkg::OPND_W-1] || (b_raw == '0);
      mau_pkg::COND_EXP_ZERO: taken = (exp == '0);
      mau_pkg::COND_EXP_EVEN: taken = !exp[0];
      default:                taken = 1'b0;
    endcase
  end

  assign is_red = (cw.uop == mau_pkg::UOP_RED_A)     || (cw.uop == mau_pkg::UOP_RED_B) ||
                  (cw.uop == mau_pkg::UOP_RED_P_RES) || (cw.uop == mau_pkg::UOP_RED_P_ACC) ||
                  (cw.uop == mau_pkg::UOP_RED_P_BASE);

  // a step holds while it waits on input, the reducer or a full output slot
  always_comb begin
    case (cw.uop)
      mau_pkg::UOP_LOAD: stall = !in_valid;
      mau_pkg::UOP_OUT:  stall = out_valid && !out_ready;
      default:           stall = is_red && !red_stat.done;
    endcase
  end

  assign advance = !stall;
  assign pc_next = !advance ? pc : (taken ? cw.target : pc + mau_pkg::PC_W'(1));

  assign in_ready  = (cw.uop == mau_pkg::UOP_LOAD);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= mau_pkg::S_LOAD;
      mod_value <= mau_pkg::MOD_RESET;
    end else begin
      pc <= pc_next;
      if (cfg_valid && cfg_ready) mod_value <= modulus;
    end
  end

  // --------------------------------------------------------------------------
  // Shared reducer: operands are reduced from sign and magnitude, products
  // from the 62-bit multiplier register.
  // --------------------------------------------------------------------------
  always_comb begin
    red_req.start  = is_red && red_stat.idle;
    red_req.negate = 1'b0;
    case (cw.uop)
      mau_pkg::UOP_RED_A: begin
        red_value      = a_raw;
        red_req.negate = a_raw[mau_pkg::OPND_W-1];
      end
      mau_pkg::UOP_RED_B: begin
        red_value      = b_raw;
        red_req.negate = b_raw[mau_pkg::OPND_W-1];
      end
      default: red_value = mau_pkg::OPND_W'(prod);
    endcase
  end

  mau_reduce u_reduce (
    .clk     (clk),
    .rst     (rst),
    .req     (red_req),
    .value   (red_value),
    .m       (mod_value),
    .stat    (red_stat),
    .residue (red_residue)
  );

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_comb begin
    case (cw.uop)
      mau_pkg::UOP_PMUL_ACC_BASE: begin
        mul_x = acc;
        mul_y = base;
      end
      mau_pkg::UOP_PMUL_BASE_SQ: begin
        mul_x = base;
        mul_y = base;
      end
      mau_pkg::UOP_PMUL_RA_ACC: begin
        mul_x = ra;
        mul_y = acc;
      end
      default: begin
        mul_x = ra;
        mul_y = rb;
      end
    endcase
  end

  assign sum  = {1'b0, ra} + {1'b0, rb};
  assign diff = {1'b0, ra} + {1'b0, mod_value} - {1'b0, rb};

  always_ff @(posedge clk) begin
    case (cw.uop)
      mau_pkg::UOP_LOAD: begin
        if (in_valid) begin
          cmd   <= command;
          a_raw <= $unsigned(operand_a);
          b_raw <= $unsigned(operand_b);
        end
      end
      mau_pkg::UOP_RED_A: if (red_stat.done) ra <= red_residue;
      mau_pkg::UOP_RED_B: if (red_stat.done) rb <= red_residue;
      mau_pkg::UOP_ADD: begin
        res <= (sum >= {1'b0, mod_value}) ? mau_pkg::MOD_W'(sum - {1'b0, mod_value})
                                          : mau_pkg::MOD_W'(sum);
      end
      mau_pkg::UOP_SUB: begin
        res <= (ra >= rb) ? (ra - rb) : mau_pkg::MOD_W'(diff);
      end
      mau_pkg::UOP_ZERO: res <= '0;
      mau_pkg::UOP_ONE:  res <= mau_pkg::MOD_W'(1);
      mau_pkg::UOP_PMUL_AB,
      mau_pkg::UOP_PMUL_ACC_BASE,
      mau_pkg::UOP_PMUL_BASE_SQ,
      mau_pkg::UOP_PMUL_RA_ACC: begin
        prod <= mau_pkg::PROD_W'(mul_x) * mau_pkg::PROD_W'(mul_y);
      end
      mau_pkg::UOP_RED_P_RES:  if (red_stat.done) res  <= red_residue;
      mau_pkg::UOP_RED_P_ACC:  if (red_stat.done) acc  <= red_residue;
      mau_pkg::UOP_RED_P_BASE: if (red_stat.done) base <= red_residue;
      // Fermat inverse: rb^(m-2)
      mau_pkg::UOP_INIT_DIV: begin
        acc  <= mau_pkg::MOD_W'(1);
        base <= rb;
        exp  <= mau_pkg::OPND_W'(mod_value) - mau_pkg::OPND_W'(2);
      end
      mau_pkg::UOP_INIT_POW: begin
        acc  <= mau_pkg::MOD_W'(1);
        base <= ra;
        exp  <= b_raw;
      end
      mau_pkg::UOP_EXP_SHIFT: exp <= exp >> 1;
      mau_pkg::UOP_MOV_ACC:   res <= acc;
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: holds one finished item while the next one runs
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.uop == mau_pkg::UOP_OUT && advance) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.uop == mau_pkg::UOP_OUT && advance) result <= res;
  end

endmodule

>>> test/tb_top.sv
// ============================================================================
// tb_top: modular arithmetic unit testbench
// Drives add, subtract, multiply, divide, power and unused command items
// under a sweep of modulus settings. Each accepted item is predicted in
// 64-bit unsigned arithmetic, and every result is checked in order. Both the
// input side and the result side stall at random.
// ============================================================================
module tb_top;

  localparam int          CYCLE_LIMIT  = 6_000_000;
  localparam int          DRAIN_CYCLES = 300;
  localparam int unsigned MOD_MAX      = 32'h7fff_ffff;

  // command codes the block treats as no-ops (result 0)
  localparam logic [mau_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [mau_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [mau_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

  localparam logic [mau_pkg::OPND_W-1:0] OPND_MIN = 64'h8000_0000_0000_0000;
  localparam logic [mau_pkg::OPND_W-1:0] OPND_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [mau_pkg::OPND_W-1:0] OPND_M1  = 64'hffff_ffff_ffff_ffff;

  typedef struct {
    logic [mau_pkg::CMD_W-1:0]  cmd;
    logic [mau_pkg::OPND_W-1:0] a;
    logic [mau_pkg::OPND_W-1:0] b;
  } op_item_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the modulus and a queue of the
  // residues still owed by the block.
  // --------------------------------------------------------------------------
  class residue_board;
    logic [mau_pkg::MOD_W-1:0] cur_modulus;
    logic [mau_pkg::MOD_W-1:0] awaited_residues[$];
    int                        fault_count;

    function new();
      cur_modulus = mau_pkg::MOD_RESET;
      fault_count = 0;
    endfunction

    function void set_modulus(logic [mau_pkg::MOD_W-1:0] value);
      cur_modulus = value;
    endfunction

    // nonnegative residue of a two's complement operand
    function bit [63:0] signed_residue(bit [63:0] raw, bit [63:0] m);
      bit [63:0] r;
      if (raw[63]) begin
        r = (64'd0 - raw) % m;
        return (r != 0) ? m - r : 64'd0;
      end
      return raw % m;
    endfunction

    // square-and-multiply; residues stay below 2^31 so products fit
    function bit [63:0] power_residue(bit [63:0] base, bit [63:0] ex, bit [63:0] m);
      bit [63:0] acc;
      acc = 64'd1 % m;
      while (ex != 0) begin
        if (ex[0]) acc = (acc * base) % m;
        base = (base * base) % m;
        ex   = ex >> 1;
      end
      return acc;
    endfunction

    function logic [mau_pkg::MOD_W-1:0] expected_residue(logic [mau_pkg::CMD_W-1:0] cmd,
                                                          bit [63:0] a, bit [63:0] b);
      bit [63:0] m, ra, rb, res;
      m   = 64'(cur_modulus);
      res = 0;
      if (m >= 2) begin
        ra = signed_residue(a, m);
        rb = signed_residue(b, m);
        case (cmd)
          mau_pkg::CMD_ADD: res = (ra + rb) % m;
          mau_pkg::CMD_SUB: res = (ra + m - rb) % m;
          mau_pkg::CMD_MUL: res = (ra * rb) % m;
          // Fermat inverse; a zero divisor gives 0
          mau_pkg::CMD_DIV: begin
            res = (rb == 0) ? 64'd0 : (ra * power_residue(rb, m - 2, m)) % m;
          end
          // zero or negative exponent gives 1
          mau_pkg::CMD_POW: begin
            res = (b[63] || b == 0) ? 64'd1 : power_residue(ra, b, m);
          end
          default: res = 0;
        endcase
      end
      return res[mau_pkg::MOD_W-1:0];
    endfunction

    function void note_item(logic [mau_pkg::CMD_W-1:0] cmd, logic [mau_pkg::OPND_W-1:0] a,
                            logic [mau_pkg::OPND_W-1:0] b);
      awaited_residues = {awaited_residues, expected_residue(cmd, a, b)};
    endfunction

    function void check_result(logic [mau_pkg::MOD_W-1:0] got);
      logic [mau_pkg::MOD_W-1:0] want;
      if (awaited_residues.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, got);
        fault_count++;
        return;
      end
      want = awaited_residues.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch, expected %0d, actual %0d", $time, want, got);
        fault_count++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; every input known from time 0
  // --------------------------------------------------------------------------
  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [mau_pkg::MOD_W-1:0]         modulus   = mau_pkg::MOD_RESET;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  logic [mau_pkg::CMD_W-1:0]         command   = mau_pkg::CMD_ADD;
  logic signed [mau_pkg::OPND_W-1:0] operand_a = '0;
  logic signed [mau_pkg::OPND_W-1:0] operand_b = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [mau_pkg::MOD_W-1:0]         result;

  residue_board board = new();
  bit           calm  = 1'b0;   // when set, neither side idles
  int           cycles = 0;

  modular_arithmetic_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .modulus   (modulus),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  always #5 clk = ~clk;

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("modular_arithmetic_unit verification failed");
      $finish;
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(result);
  end

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // result side: bursts of ready broken by random stalls
  initial begin
    int run_len;
    int stall;
    forever begin
      run_len = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run_len) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------
  // Starts at a falling edge after the previous item was taken; valid only drops
  // when a gap follows, so back-to-back items keep it high.
  task automatic send_item(logic [mau_pkg::CMD_W-1:0] cmd, logic [mau_pkg::OPND_W-1:0] a,
                           logic [mau_pkg::OPND_W-1:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command   <= cmd;
    operand_a <= a;
    operand_b <= b;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(cmd, a, b);
  endtask

  // drop valid and hold off until every owed result is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.awaited_residues.size() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(logic [mau_pkg::MOD_W-1:0] value);
    @(negedge clk);
    modulus   <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_modulus(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // operands: full range, small signed, near multiples of m, extremes
  function automatic logic [mau_pkg::OPND_W-1:0] pick_operand();
    longint m;
    longint v;
    m = longint'(board.cur_modulus);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = {$urandom, $urandom};
      4, 5:       v = longint'($urandom_range(0, 40)) - 20;
      6, 7: begin
        v = m * longint'($urandom_range(0, 1000)) + longint'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      8: begin
        case ($urandom_range(0, 3))
          0:       v = OPND_MIN;
          1:       v = OPND_MAX;
          2:       v = 0;
          default: v = OPND_M1;
        endcase
      end
      default: v = ($urandom_range(0, 1)) ? m - 1 : 1 - m;
    endcase
    return v;
  endfunction

  // exponents: mostly short so power items stay quick, a few full width
  function automatic logic [mau_pkg::OPND_W-1:0] pick_exponent();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return {1'b1, 31'($urandom), $urandom};
      2:       return {1'b0, 31'($urandom), $urandom};
      default: return 64'($urandom_range(1, 4095));
    endcase
  endfunction

  function automatic op_item_t random_item();
    op_item_t it;
    if ($urandom_range(0, 19) == 0) it.cmd = 3'($urandom_range(5, 7));
    else it.cmd = 3'($urandom_range(0, 4));
    it.a = pick_operand();
    it.b = (it.cmd == mau_pkg::CMD_POW) ? pick_exponent() : pick_operand();
    return it;
  endfunction

  task automatic run_phase(logic [mau_pkg::MOD_W-1:0] m, int count, bit quiet);
    op_item_t it;
    wait_drained();
    calm = quiet;
    write_modulus(m);
    for (int i = 0; i < count; i++) begin
      // now and then let the block run dry before the next item
      if ($urandom_range(0, 29) == 0) wait_drained();
      it = random_item();
      send_item(it.cmd, it.a, it.b);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed items under the reset modulus
    send_item(mau_pkg::CMD_ADD, OPND_MAX, OPND_MAX);
    send_item(mau_pkg::CMD_ADD, OPND_MIN, OPND_MIN);
    send_item(mau_pkg::CMD_ADD, 64'd1000000006, 64'd1);      // wraps to zero
    send_item(mau_pkg::CMD_SUB, 64'd0, 64'd1);               // negative difference
    send_item(mau_pkg::CMD_SUB, OPND_M1, OPND_MAX);
    send_item(mau_pkg::CMD_MUL, OPND_MAX, OPND_MIN);
    send_item(mau_pkg::CMD_MUL, OPND_M1, OPND_M1);
    send_item(mau_pkg::CMD_DIV, 64'd10, 64'd0);              // zero divisor
    send_item(mau_pkg::CMD_DIV, 64'd1, 64'd1000000007);      // divisor reduces to zero
    send_item(mau_pkg::CMD_DIV, -64'sd5, 64'd3);
    send_item(mau_pkg::CMD_DIV, OPND_MIN, OPND_M1);
    send_item(mau_pkg::CMD_POW, 64'd2, 64'd0);               // zero exponent
    send_item(mau_pkg::CMD_POW, 64'd3, OPND_M1);             // negative exponent
    send_item(mau_pkg::CMD_POW, 64'd3, OPND_MIN);
    send_item(mau_pkg::CMD_POW, 64'd0, 64'd5);
    send_item(mau_pkg::CMD_POW, -64'sd2, OPND_MAX);          // longest exponent
    send_item(mau_pkg::CMD_POW, OPND_MIN, 64'd1);
    send_item(CMD_RSVD5, OPND_MAX, OPND_M1);
    send_item(CMD_RSVD6, 64'd1, 64'd1);
    send_item(CMD_RSVD7, OPND_M1, OPND_MIN);

    // modulus sweep: smallest, largest prime, degenerate, small and random
    run_phase(31'd2, 12, 1'b0);
    run_phase(MOD_MAX[mau_pkg::MOD_W-1:0], 14, 1'b0);
    run_phase(31'd0, 8, 1'b1);
    run_phase(31'd1, 8, 1'b0);
    run_phase(31'd3, 12, 1'b1);
    run_phase(31'd65537, 16, 1'b0);
    run_phase(31'($urandom_range(2, MOD_MAX)), 16, 1'b0);
    run_phase(31'($urandom_range(4, 5000)), 17, 1'b0);
    run_phase(mau_pkg::MOD_RESET, 17, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.fault_count == 0) begin
      $display("modular_arithmetic_unit verification clean");
    end else begin
      $display("modular_arithmetic_unit verification failed");
    end
    $finish;
  end

endmodule
